[src/set_assoc_cache_random_replace_assert.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef SET_ASSOC_CACHE_RANDOM_REPLACE_ASSERT_SVH
`define SET_ASSOC_CACHE_RANDOM_REPLACE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SARC_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("sarc assertion failed");

// condition implies consequence in the next cycle
`define SARC_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("sarc assertion failed");

`endif

[src/sarc_pkg.sv]
package sarc_pkg;
	localparam int SETS       = 128;
	localparam int WAYS       = 8;
	localparam int LINE_BYTES = 64;
	localparam int WORDS      = LINE_BYTES / 8;

	localparam int ADDR_W  = 32;
	localparam int OFF_W   = $clog2(LINE_BYTES);
	localparam int SET_W   = $clog2(SETS);
	localparam int WAY_W   = $clog2(WAYS);
	localparam int WORD_W  = $clog2(WORDS);
	localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
	localparam int DADDR_W = SET_W + WAY_W + WORD_W;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 112;
	localparam int SEED_W     = 16;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_FILL  = 2'd2;

	localparam logic [2:0] KIND_READ   = 3'd0;
	localparam logic [2:0] KIND_WDONE  = 3'd1;
	localparam logic [2:0] KIND_MEMWR  = 3'd2;
	localparam logic [2:0] KIND_WBACK  = 3'd3;
	localparam logic [2:0] KIND_FREQ   = 3'd4;
	localparam logic [2:0] KIND_REJECT = 3'd5;

	localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

	// galois lfsr, one step
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
		logic [SEED_W-1:0] r;
		r = v >> 1;
		if (v[0]) begin
			r = r ^ LFSR_MASK;
		end
		return r;
	endfunction
endpackage

[src/sarc_ram.sv]
module sarc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/set_assoc_cache_random_replace.sv]
// channel   | dir | tdata (low bit up)                                  | tuser     | tlast
// s_*       | in  | address[31:0] write_byte[39:32] fill_word[103:40]  | action    | -
// m_*       | out | read_byte[7:0] mem_address[39:8] mem_data[103:40]  | kind      | last
//           |     | hit[104], zero pad to 112                           |           |
// seed_*    | in  | seed_wdata loads the replacement lfsr when seed_we is high
//
// one transaction at a time; s_tready is high only while the sequencer is idle
// hit: tag read, data read, result; fill word: written on acceptance, the final one then completes the line and replies
// miss: tag read, lookup, allocation and fill request, plus a writeback when a valid line is evicted,
// one writeback word per cycle unless m_tready stalls it, paced by the single read port of the data memory
// after arst_n a clearing pass writes every valid row to zero; tag and data are not cleared
// with m_tvalid high, m_tready low holds any step that emits a result; that result stays registered
module set_assoc_cache_random_replace (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [sarc_pkg::IN_DATA_W-1:0]       s_tdata,   // address, write_byte, fill_word
	input  logic [1:0]                           s_tuser,   // action
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [sarc_pkg::OUT_DATA_W-1:0]      m_tdata,   // read_byte, mem_address, mem_data, hit
	output logic [2:0]                           m_tuser,   // kind
	output logic                                 m_tlast,
	input  logic                                 seed_we,
	input  logic [sarc_pkg::SEED_W-1:0]          seed_wdata
);
	import sarc_pkg::*;

	`include "set_assoc_cache_random_replace_assert.svh"

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LOOKUP  = 4'd1;
	localparam logic [3:0] ST_HIT     = 4'd2;
	localparam logic [3:0] ST_ALLOC   = 4'd3;
	localparam logic [3:0] ST_WB      = 4'd4;
	localparam logic [3:0] ST_FREQ    = 4'd5;
	localparam logic [3:0] ST_FILLEND = 4'd6;
	localparam logic [3:0] ST_FILLRSP = 4'd7;
	localparam logic [3:0] ST_REJECT  = 4'd8;
	localparam logic [3:0] ST_CLEAR   = 4'd9;

	logic [3:0]        state_q;
	logic [1:0]        act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        wbyte_q;
	logic              miss_pending_q;
	logic [ADDR_W-1:0] miss_addr_q;
	logic              miss_write_q;
	logic [WAY_W-1:0]  miss_way_q;
	logic [WORD_W-1:0] fill_cnt_q;
	logic [SEED_W-1:0] lfsr_q;
	logic [WAY_W-1:0]  way_q;
	logic [WORD_W-1:0] wcnt_q;
	logic [TAG_W-1:0]  vtag_q;
	logic [SET_W-1:0]  clr_q;

	// input fields
	logic [ADDR_W-1:0] in_addr;
	logic [7:0]        in_wbyte;
	logic [63:0]       in_fill;
	logic              s_acc;

	assign in_addr  = s_tdata[31:0];
	assign in_wbyte = s_tdata[39:32];
	assign in_fill  = s_tdata[103:40];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// fields of the current access and the pending miss
	logic [SET_W-1:0]  cur_set, miss_set;
	logic [TAG_W-1:0]  cur_tag, miss_tag;
	logic [WORD_W-1:0] cur_word, miss_word;
	logic [5:0]        cur_sh, miss_sh;

	assign cur_set   = addr_q[OFF_W +: SET_W];
	assign cur_tag   = addr_q[ADDR_W-1 -: TAG_W];
	assign cur_word  = addr_q[3 +: WORD_W];
	assign cur_sh    = {addr_q[2:0], 3'b000};
	assign miss_set  = miss_addr_q[OFF_W +: SET_W];
	assign miss_tag  = miss_addr_q[ADDR_W-1 -: TAG_W];
	assign miss_word = miss_addr_q[3 +: WORD_W];
	assign miss_sh   = {miss_addr_q[2:0], 3'b000};

	// tag memories, one per way
	logic             tag_re, tag_we;
	logic [TAG_W-1:0] tag_rd [WAYS];

	assign tag_re = s_acc && (s_tuser == ACT_READ || s_tuser == ACT_WRITE) && !miss_pending_q;
	assign tag_we = (state_q == ST_FILLEND);

	for (genvar g = 0; g < WAYS; g++) begin : g_tag
		sarc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag (
			.clk   (clk),
			.we    (tag_we && (miss_way_q == WAY_W'(g))),
			.waddr (miss_set),
			.wdata (miss_tag),
			.re    (tag_re),
			.raddr (in_addr[OFF_W +: SET_W]),
			.rdata (tag_rd[g])
		);
	end

	// valid memory, one row per set; a fill reads the row of the pending miss
	logic             v_we, v_re;
	logic [SET_W-1:0] v_waddr, v_raddr;
	logic [WAYS-1:0]  v_wdata, valid_rd;

	assign v_re    = s_acc;
	assign v_raddr = (s_tuser == ACT_FILL) ? miss_set : in_addr[OFF_W +: SET_W];

	sarc_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.re    (v_re),
		.raddr (v_raddr),
		.rdata (valid_rd)
	);

	// data memory
	logic               d_we, d_re;
	logic [DADDR_W-1:0] d_waddr, d_raddr;
	logic [63:0]        d_wdata, d_rdata;

	sarc_ram #(.WIDTH(64), .DEPTH(SETS * WAYS * WORDS)) u_data (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// hit search and way allocation
	logic [WAYS-1:0]   row_valid;
	logic              hit_any, free_any;
	logic [WAY_W-1:0]  hit_way, free_way, vway;
	logic [SEED_W-1:0] lfsr_nxt;

	assign row_valid = valid_rd;
	assign lfsr_nxt  = lfsr_step(lfsr_q);
	assign vway      = lfsr_nxt[WAY_W-1:0];

	always_comb begin
		hit_any  = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_valid[w] && tag_rd[w] == cur_tag) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row_valid[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// valid row updates: clearing pass, victim drop, line completion
	always_comb begin
		v_we    = 1'b0;
		v_waddr = '0;
		v_wdata = '0;
		if (state_q == ST_CLEAR) begin
			v_we    = 1'b1;
			v_waddr = clr_q;
		end else if (state_q == ST_ALLOC && !free_any) begin
			v_we    = 1'b1;
			v_waddr = cur_set;
			v_wdata = row_valid & ~(WAYS'(1) << vway);
		end else if (state_q == ST_FILLEND) begin
			v_we    = 1'b1;
			v_waddr = miss_set;
			v_wdata = valid_rd | (WAYS'(1) << miss_way_q);
		end
	end

	// result selection
	logic              out_free, emit;
	logic [2:0]        e_kind;
	logic [7:0]        e_rbyte;
	logic [ADDR_W-1:0] e_maddr;
	logic [63:0]       e_mdata;
	logic              e_hit, e_last;
	logic [7:0]        hit_byte, miss_byte;
	logic [63:0]       merged;

	assign out_free  = !m_tvalid || m_tready;
	assign hit_byte  = 8'(d_rdata >> cur_sh);
	assign miss_byte = 8'(d_rdata >> miss_sh);
	assign merged    = (d_rdata & ~(64'hff << cur_sh)) | (64'(wbyte_q) << cur_sh);

	always_comb begin
		emit    = 1'b0;
		e_kind  = KIND_REJECT;
		e_rbyte = '0;
		e_maddr = '0;
		e_mdata = '0;
		e_hit   = 1'b0;
		e_last  = 1'b0;
		d_we    = 1'b0;
		d_waddr = '0;
		d_wdata = '0;
		d_re    = 1'b0;
		d_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				// fill word goes straight into the line being filled
				if (s_acc && s_tuser == ACT_FILL && miss_pending_q) begin
					d_we    = 1'b1;
					d_waddr = {miss_set, miss_way_q, fill_cnt_q};
					d_wdata = in_fill;
				end
			end
			ST_LOOKUP: begin
				if (hit_any) begin
					d_re    = 1'b1;
					d_raddr = {cur_set, hit_way, cur_word};
				end else if (act_q == ACT_WRITE) begin
					// write miss: byte goes out to memory first
					emit    = 1'b1;
					e_kind  = KIND_MEMWR;
					e_maddr = addr_q;
					e_mdata = 64'(wbyte_q);
				end
			end
			ST_HIT: begin
				emit  = 1'b1;
				e_hit = 1'b1;
				e_last = 1'b1;
				if (act_q == ACT_READ) begin
					e_kind  = KIND_READ;
					e_rbyte = hit_byte;
				end else begin
					e_kind  = KIND_WDONE;
					d_we    = out_free;
					d_waddr = {cur_set, way_q, cur_word};
					d_wdata = merged;
				end
			end
			ST_ALLOC: begin
				if (!free_any) begin
					d_re    = 1'b1;
					d_raddr = {cur_set, vway, {WORD_W{1'b0}}};
				end
			end
			ST_WB: begin
				emit    = 1'b1;
				e_kind  = KIND_WBACK;
				e_maddr = {vtag_q, cur_set, wcnt_q, 3'b000};
				e_mdata = d_rdata;
				d_re    = out_free;
				d_raddr = {cur_set, way_q, wcnt_q + WORD_W'(1)};
			end
			ST_FREQ: begin
				emit    = 1'b1;
				e_kind  = KIND_FREQ;
				e_maddr = {addr_q[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
				e_last  = 1'b1;
			end
			ST_FILLEND: begin
				d_re    = 1'b1;
				d_raddr = {miss_set, miss_way_q, miss_word};
			end
			ST_FILLRSP: begin
				emit   = 1'b1;
				e_last = 1'b1;
				if (miss_write_q) begin
					e_kind = KIND_WDONE;
				end else begin
					e_kind  = KIND_READ;
					e_rbyte = miss_byte;
				end
			end
			ST_REJECT: begin
				emit   = 1'b1;
				e_kind = KIND_REJECT;
				e_last = 1'b1;
			end
			ST_CLEAR: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			m_tdata <= {7'd0, e_hit, e_mdata, e_maddr, e_rbyte};
			m_tuser <= e_kind;
			m_tlast <= e_last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			miss_pending_q <= 1'b0;
			miss_addr_q    <= '0;
			miss_write_q   <= 1'b0;
			miss_way_q     <= '0;
			fill_cnt_q     <= '0;
			lfsr_q         <= SEED_W'(1);
			act_q          <= '0;
			addr_q         <= '0;
			wbyte_q        <= '0;
			way_q          <= '0;
			wcnt_q         <= '0;
			vtag_q         <= '0;
		end else begin
			if (seed_we) begin
				lfsr_q <= (seed_wdata == '0) ? SEED_W'(1) : seed_wdata;
			end else if (state_q == ST_ALLOC && !free_any) begin
				lfsr_q <= lfsr_nxt;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						act_q   <= s_tuser;
						addr_q  <= in_addr;
						wbyte_q <= in_wbyte;
						if (s_tuser == ACT_READ || s_tuser == ACT_WRITE) begin
							state_q <= miss_pending_q ? ST_REJECT : ST_LOOKUP;
						end else if (s_tuser == ACT_FILL && miss_pending_q) begin
							fill_cnt_q <= fill_cnt_q + WORD_W'(1);
							if (fill_cnt_q == WORD_W'(WORDS - 1)) begin
								state_q <= ST_FILLEND;
							end
						end else begin
							state_q <= ST_REJECT;
						end
					end
				end
				ST_LOOKUP: begin
					if (hit_any) begin
						way_q   <= hit_way;
						state_q <= ST_HIT;
					end else if (act_q != ACT_WRITE || out_free) begin
						state_q <= ST_ALLOC;
					end
				end
				ST_HIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ALLOC: begin
					if (free_any) begin
						way_q   <= free_way;
						state_q <= ST_FREQ;
					end else begin
						way_q   <= vway;
						vtag_q  <= tag_rd[vway];
						wcnt_q  <= '0;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						wcnt_q <= wcnt_q + WORD_W'(1);
						if (wcnt_q == WORD_W'(WORDS - 1)) begin
							state_q <= ST_FREQ;
						end
					end
				end
				ST_FREQ: begin
					if (out_free) begin
						miss_pending_q <= 1'b1;
						miss_addr_q    <= addr_q;
						miss_write_q   <= (act_q == ACT_WRITE);
						miss_way_q     <= way_q;
						fill_cnt_q     <= '0;
						state_q        <= ST_IDLE;
					end
				end
				ST_FILLEND: begin
					miss_pending_q <= 1'b0;
					state_q        <= ST_FILLRSP;
				end
				ST_FILLRSP, ST_REJECT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`SARC_ASSERT_SAME(a_fill_cnt_idle, !miss_pending_q, fill_cnt_q == '0)
	`SARC_ASSERT_SAME(a_lfsr_nonzero, 1'b1, lfsr_q != '0)
	`SARC_ASSERT_NEXT(a_alloc_to_wb, state_q == ST_ALLOC && !free_any, state_q == ST_WB && wcnt_q == '0)
	`SARC_ASSERT_NEXT(a_freq_arms_miss, state_q == ST_FREQ && out_free, miss_pending_q)
endmodule

[dv/tb_set_assoc_cache_random_replace.sv]
module tb_set_assoc_cache_random_replace;
	import sarc_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [7:0]  write_byte;
		logic [63:0] fill_word;
	} access_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  read_byte;
		logic [31:0] mem_address;
		logic [63:0] mem_data;
		logic        hit;
		logic        last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic seed_we = 1'b0;
	logic [SEED_W-1:0] seed_wdata = '0;

	set_assoc_cache_random_replace i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .seed_we(seed_we), .seed_wdata(seed_wdata)
	);

	always #4 clk = ~clk;

	// shadow copy of the cache contents and miss tracking
	logic        shadow_valid [SETS*WAYS];
	logic [TAG_W-1:0] shadow_tag [SETS*WAYS];
	logic [63:0] shadow_words [SETS*WAYS*WORDS];
	logic        pend_miss;
	logic [31:0] pend_addr;
	logic        pend_write;
	int unsigned pend_way;
	int unsigned pend_count;
	logic [15:0] victim_lfsr;

	access_t pending_accesses[$];
	reply_t  expected_replies[$];
	int      error_count = 0;
	int      send_idle_pct = 9;
	int      recv_idle_pct = 61;
	bit      hold_sender = 1'b0;
	bit      stim_done = 1'b0;
	int      stall_cycles = 0;
	// the base addresses of every line filled or queued for a fill, to aim accesses at likely hits
	logic [31:0] touched_lines[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void push_reply(input logic [2:0] k, input logic [7:0] rb,
			input logic [31:0] ma, input logic [63:0] md, input logic h, input logic l);
		reply_t r;
		r.kind = k; r.read_byte = rb; r.mem_address = ma; r.mem_data = md;
		r.hit = h; r.last = l;
		expected_replies.push_back(r);
	endfunction

	function automatic logic [7:0] line_byte(input int unsigned ln, input logic [5:0] off);
		logic [63:0] w;
		w = shadow_words[ln*WORDS + off[5:3]];
		return w[off[2:0]*8 +: 8];
	endfunction

	// predict the replies caused by one accepted transaction
	function automatic void predict_access(input access_t t);
		int unsigned set, ln, w, i;
		logic [TAG_W-1:0] tg;
		logic [5:0] off;
		int hit_way;
		bit found;
		logic [31:0] base;
		set = t.address[OFF_W +: SET_W];
		tg = t.address[31 -: TAG_W];
		off = t.address[OFF_W-1:0];
		if (t.action == ACT_READ || t.action == ACT_WRITE) begin
			if (pend_miss) begin
				push_reply(KIND_REJECT, 0, 0, 0, 0, 1);
				return;
			end
			hit_way = -1;
			for (w = 0; w < WAYS; w++)
				if (hit_way < 0 && shadow_valid[set*WAYS+w] && shadow_tag[set*WAYS+w] == tg)
					hit_way = w;
			if (hit_way >= 0) begin
				ln = set*WAYS + hit_way;
				if (t.action == ACT_READ) begin
					push_reply(KIND_READ, line_byte(ln, off), 0, 0, 1, 1);
				end else begin
					shadow_words[ln*WORDS + off[5:3]][off[2:0]*8 +: 8] = t.write_byte;
					push_reply(KIND_WDONE, 0, 0, 0, 1, 1);
				end
				return;
			end
			if (t.action == ACT_WRITE)
				push_reply(KIND_MEMWR, 0, t.address, {56'd0, t.write_byte}, 0, 0);
			found = 0;
			for (w = 0; w < WAYS && !found; w++)
				if (!shadow_valid[set*WAYS+w]) begin
					found = 1;
					pend_way = w;
				end
			if (!found) begin
				victim_lfsr = {1'b0, victim_lfsr[15:1]} ^ (victim_lfsr[0] ? LFSR_MASK : 16'd0);
				pend_way = victim_lfsr % WAYS;
				ln = set*WAYS + pend_way;
				base = {shadow_tag[ln], set[SET_W-1:0], {OFF_W{1'b0}}};
				for (i = 0; i < WORDS; i++)
					push_reply(KIND_WBACK, 0, base + i*8, shadow_words[ln*WORDS+i], 0, 0);
				shadow_valid[ln] = 0;
			end
			push_reply(KIND_FREQ, 0, {t.address[31:OFF_W], {OFF_W{1'b0}}}, 0, 0, 1);
			pend_miss = 1;
			pend_addr = t.address;
			pend_write = (t.action == ACT_WRITE);
			pend_count = 0;
		end else if (t.action == ACT_FILL && pend_miss) begin
			ln = pend_addr[OFF_W +: SET_W]*WAYS + pend_way;
			shadow_words[ln*WORDS + pend_count] = t.fill_word;
			pend_count++;
			if (pend_count < WORDS) return;
			pend_miss = 0;
			shadow_valid[ln] = 1;
			shadow_tag[ln] = pend_addr[31 -: TAG_W];
			touched_lines.push_back({pend_addr[31:OFF_W], {OFF_W{1'b0}}});
			if (pend_write) push_reply(KIND_WDONE, 0, 0, 0, 0, 1);
			else push_reply(KIND_READ, line_byte(ln, pend_addr[OFF_W-1:0]), 0, 0, 0, 1);
		end else begin
			push_reply(KIND_REJECT, 0, 0, 0, 0, 1);
		end
	endfunction

	// driver: pops the next pending transaction and holds it until accepted
	always @(posedge clk) begin
		access_t nx;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_access({s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[103:40]});
			if (!s_tvalid || s_tready) begin
				if (pending_accesses.size() > 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					nx = pending_accesses.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nx.action;
					s_tdata <= {nx.fill_word, nx.write_byte, nx.address};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: compares every accepted reply with the oldest expectation
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected reply kind", 64'(m_tuser), 64'd0);
				end else begin
					want = expected_replies.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
					if (m_tdata[7:0] !== want.read_byte)
						report_mismatch("read_byte", 64'(m_tdata[7:0]), 64'(want.read_byte));
					if (m_tdata[39:8] !== want.mem_address)
						report_mismatch("mem_address", 64'(m_tdata[39:8]),
							64'(want.mem_address));
					if (m_tdata[103:40] !== want.mem_data)
						report_mismatch("mem_data", m_tdata[103:40], want.mem_data);
					if (m_tdata[104] !== want.hit)
						report_mismatch("hit", 64'(m_tdata[104]), 64'(want.hit));
					if (m_tlast !== want.last)
						report_mismatch("last", 64'(m_tlast), 64'(want.last));
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic access_t make_access(input logic [1:0] act, input logic [31:0] a,
			input logic [7:0] b, input logic [63:0] f);
		access_t t;
		t.action = act; t.address = a; t.write_byte = b; t.fill_word = f;
		return t;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_access(input access_t t);
		pending_accesses.push_back(t);
	endtask

	// read or write miss followed by a full set of fill words
	task automatic queue_miss_and_fill(input logic [1:0] act, input logic [31:0] a);
		queue_access(make_access(act, a, 8'($urandom), 0));
		for (int i = 0; i < WORDS; i++) queue_access(make_access(ACT_FILL, 0, 0, rand_word()));
	endtask

	// wait until every queued transaction was sent and every reply came back
	task automatic drain();
		while (pending_accesses.size() > 0 || s_tvalid || expected_replies.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_seed(input logic [15:0] v);
		@(posedge clk);
		seed_we <= 1'b1;
		seed_wdata <= v;
		@(posedge clk);
		seed_we <= 1'b0;
		victim_lfsr = (v == 0) ? 16'd1 : v;
	endtask

	// random traffic, mostly well-formed miss/fill sequences and hits
	task automatic queue_random(input int n);
		logic [31:0] a;
		int sel;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			if (touched_lines.size() > 0 && sel < 45) begin
				a = touched_lines[$urandom_range(touched_lines.size()-1)] | $urandom_range(63);
				queue_access(make_access(2'($urandom_range(1)), a, 8'($urandom), rand_word()));
			end else if (sel < 80) begin
				// few sets so that every way fills and evictions happen
				a = {7'($urandom_range(2) ? $urandom_range(15) : $urandom), 25'd0};
				a = (a & 32'hffffe000) | ($urandom_range(3) << OFF_W) | $urandom_range(63);
				if ($urandom_range(9) == 0) a = $urandom;
				queue_miss_and_fill(2'($urandom_range(1)), a);
				k += WORDS;
				touched_lines.push_back({a[31:OFF_W], {OFF_W{1'b0}}});
			end else begin
				queue_access(make_access(2'($urandom_range(3)), $urandom, 8'($urandom),
					rand_word()));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < SETS*WAYS; i++) shadow_valid[i] = 0;
		pend_miss = 0; pend_addr = 0; pend_write = 0; pend_way = 0; pend_count = 0;
		victim_lfsr = 16'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_seed(16'd1);

		// directed: rejects, extremes of address and data, every action
		queue_access(make_access(ACT_FILL, 0, 0, '1));
		queue_access(make_access(2'd3, '1, '1, '1));
		queue_miss_and_fill(ACT_READ, 32'hffffffff);
		queue_access(make_access(ACT_READ, 32'hffffffc0, 0, 0));
		queue_access(make_access(ACT_WRITE, 32'hffffffff, 8'hff, 0));
		queue_access(make_access(ACT_READ, 32'hffffffff, 0, 0));
		queue_access(make_access(ACT_WRITE, 32'h0, 8'h00, 0));
		// access during a pending miss is rejected
		queue_access(make_access(ACT_READ, 32'h0, 0, 0));
		queue_access(make_access(2'd3, 0, 0, 0));
		for (int i = 0; i < WORDS; i++) queue_access(make_access(ACT_FILL, 0, 0, 64'h0));
		drain();

		// fill all ways of set zero, then evict with extreme seeds
		hold_sender = 1'b0;
		load_seed(16'hffff);
		for (int w = 1; w < WAYS + 3; w++) queue_miss_and_fill(ACT_READ, w << 13);
		drain();
		load_seed(16'd0);
		queue_random(40);
		while (pending_accesses.size() > 20) @(posedge clk);
		// sender waits here until every reply came back
		hold_sender = 1'b1;
		while (expected_replies.size() > 0 || s_tvalid) @(posedge clk);
		hold_sender = 1'b0;
		drain();

		send_idle_pct = 61; recv_idle_pct = 9;
		load_seed(16'($urandom_range(65535, 1)));
		queue_random(40);
		drain();

		send_idle_pct = 0; recv_idle_pct = 0;
		load_seed(16'h8000);
		queue_random(40);
		drain();

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
